[rtl/gve_pkg.sv]
// Shared constants, types and state codes for the velocity estimator.
package gve_pkg;

    localparam int DIV_NW      = 53;
    localparam int DIV_DW      = 32;
    localparam int DIV_CW      = 6;
    localparam int CNT_W       = 5;
    localparam int AVG_TAPS_DEF = 5;

    localparam logic [19:0] SCALE_US   = 20'd1000000;
    localparam logic [19:0] MIN_RST    = 20'd1000;
    localparam logic [9:0]  LIM_RST    = 10'd20;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_SHORT   = 2'd1;
    localparam logic [1:0] ST_OUTLIER = 2'd2;

    localparam logic REG_MIN = 1'b0;
    localparam logic REG_LIM = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_MUL,
        S_DIV1,
        S_DIV1W,
        S_SAT,
        S_DIFF,
        S_SQ,
        S_CMP,
        S_SUM,
        S_DIV2,
        S_DIV2W,
        S_PUSH,
        S_DONE
    } t_state;

endpackage

[rtl/gated_velocity_estimator.sv]
// Top level: gated finite-difference velocity estimator with moving average.
// The first sample gives no output word; a short interval goes from S_CHECK to S_DONE,
// an outlier from S_CMP, and an accepted sample passes two 53-step divider runs.
// One word at a time; the next word can be taken in the same cycle that o_valid rises,
// and a finished word holds in S_DONE while the output register is full and i_ready is low.
// Synchronous reset restores register defaults and forgets the last sample.
module gated_velocity_estimator #(
    parameter int AVG_TAPS = gve_pkg::AVG_TAPS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [31:0] i_pos_z,
    input  logic [31:0]        i_stamp_us,
    output logic               o_valid,
    input  logic               i_ready,
    output logic signed [31:0] o_out_pos_x,
    output logic signed [31:0] o_out_pos_y,
    output logic signed [31:0] o_out_pos_z,
    output logic signed [31:0] o_vel_x,
    output logic signed [31:0] o_vel_y,
    output logic signed [31:0] o_vel_z,
    output logic [1:0]         o_sample_status,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int HL = AVG_TAPS - 1;
    localparam int SW = 32 + $clog2(AVG_TAPS);
    localparam int NW = gve_pkg::DIV_NW;

    gve_pkg::t_state r_state, n_state;

    logic [19:0]        r_min;
    logic [9:0]         r_lim;
    logic               r_started;
    logic signed [31:0] r_pos  [3];
    logic signed [31:0] r_last [3];
    logic [31:0]        r_stamp;
    logic [31:0]        r_last_time;
    logic [31:0]        r_dt;
    logic               r_neg  [3];
    logic [32:0]        r_mag  [3];
    logic [NW-1:0]      r_num  [3];
    logic [41:0]        r_t;
    logic signed [31:0] r_vel  [3];
    logic [31:0]        r_d    [3];
    logic [63:0]        r_prod;
    logic [65:0]        r_sum;
    logic [83:0]        r_thr;
    logic signed [SW-1:0] r_acc [3];
    logic signed [31:0] r_hist [3][HL];
    logic signed [31:0] r_fv   [3];
    logic [1:0]         r_status;
    logic [gve_pkg::CNT_W-1:0] r_cnt;
    logic               r_ovalid;
    logic signed [31:0] r_opos [3];
    logic signed [31:0] r_ovel [3];
    logic [1:0]         r_ostat;

    logic               w_accept;
    logic               w_cfg_wr;
    logic [31:0]        w_dt;
    logic               w_short;
    logic               w_start;
    logic               w_phase2;
    logic               w_busy;
    logic [NW-1:0]      w_quo  [3];
    logic [NW-1:0]      w_dvd  [3];
    logic [31:0]        w_dvs;
    logic [31:0]        w_ma, w_mb;
    logic               w_load;
    logic               w_busy_v [3];

    assign w_accept = i_valid && o_ready;
    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign pready   = 1'b1;
    assign prdata   = (paddr[2] == gve_pkg::REG_LIM) ? {22'b0, r_lim} : {12'b0, r_min};

    assign w_dt    = r_stamp - r_last_time;
    assign w_short = (w_dt == 32'd0) || (w_dt < {12'b0, r_min});
    assign w_load  = (r_state == gve_pkg::S_DONE) && (!r_ovalid || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min <= gve_pkg::MIN_RST;
            r_lim <= gve_pkg::LIM_RST;
        end else if (w_cfg_wr) begin
            unique case (paddr[2])
                gve_pkg::REG_MIN: r_min <= pwdata[19:0];
                gve_pkg::REG_LIM: r_lim <= pwdata[9:0];
                default: ;
            endcase
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            gve_pkg::S_IDLE:  if (w_accept && r_started) n_state = gve_pkg::S_CHECK;
            gve_pkg::S_CHECK: n_state = w_short ? gve_pkg::S_DONE : gve_pkg::S_MUL;
            gve_pkg::S_MUL:   n_state = gve_pkg::S_DIV1;
            gve_pkg::S_DIV1:  n_state = gve_pkg::S_DIV1W;
            gve_pkg::S_DIV1W: if (!w_busy) n_state = gve_pkg::S_SAT;
            gve_pkg::S_SAT:   n_state = gve_pkg::S_DIFF;
            gve_pkg::S_DIFF:  n_state = gve_pkg::S_SQ;
            gve_pkg::S_SQ:    if (r_cnt == gve_pkg::CNT_W'(6)) n_state = gve_pkg::S_CMP;
            gve_pkg::S_CMP:   n_state = ({18'b0, r_sum} > r_thr) ? gve_pkg::S_DONE
                                                                 : gve_pkg::S_SUM;
            gve_pkg::S_SUM:   if (r_cnt == gve_pkg::CNT_W'(HL - 1)) n_state = gve_pkg::S_DIV2;
            gve_pkg::S_DIV2:  n_state = gve_pkg::S_DIV2W;
            gve_pkg::S_DIV2W: if (!w_busy) n_state = gve_pkg::S_PUSH;
            gve_pkg::S_PUSH:  n_state = gve_pkg::S_DONE;
            gve_pkg::S_DONE:  if (w_load) n_state = gve_pkg::S_IDLE;
            default:          n_state = gve_pkg::S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_ready  = 1'b0;
        w_start  = 1'b0;
        w_phase2 = 1'b0;
        unique case (r_state)
            gve_pkg::S_IDLE: o_ready = 1'b1;
            gve_pkg::S_DIV1: w_start = 1'b1;
            gve_pkg::S_DIV2: begin
                w_start  = 1'b1;
                w_phase2 = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gve_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign w_dvs = w_phase2 ? 32'(AVG_TAPS) : r_dt;
    assign w_busy = w_busy_v[0] | w_busy_v[1] | w_busy_v[2];

    for (genvar g = 0; g < 3; g++) begin : g_div
        logic [SW-1:0] w_amag;
        assign w_amag  = r_acc[g][SW-1] ? SW'(-r_acc[g]) : SW'(r_acc[g]);
        assign w_dvd[g] = w_phase2 ? NW'(w_amag) : r_num[g];
        gve_div u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_start (w_start),
            .i_dvd   (w_dvd[g]),
            .i_dvs   (w_dvs),
            .o_quo   (w_quo[g]),
            .o_busy  (w_busy_v[g])
        );
    end

    always_comb begin
        w_ma = '0;
        w_mb = '0;
        unique case (r_cnt)
            gve_pkg::CNT_W'(0): begin w_ma = r_d[0]; w_mb = r_d[0]; end
            gve_pkg::CNT_W'(1): begin w_ma = r_d[1]; w_mb = r_d[1]; end
            gve_pkg::CNT_W'(2): begin w_ma = r_d[2]; w_mb = r_d[2]; end
            gve_pkg::CNT_W'(3): begin w_ma = 32'(r_t[41:21]); w_mb = 32'(r_t[41:21]); end
            gve_pkg::CNT_W'(4): begin w_ma = 32'(r_t[41:21]); w_mb = 32'(r_t[20:0]); end
            gve_pkg::CNT_W'(5): begin w_ma = 32'(r_t[20:0]); w_mb = 32'(r_t[20:0]); end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_load) begin
            r_ovalid <= 1'b1;
        end else if (i_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started <= 1'b0;
            r_cnt     <= '0;
            for (int k = 0; k < 3; k++) begin
                r_fv[k] <= '0;
                for (int j = 0; j < HL; j++) r_hist[k][j] <= '0;
            end
        end else begin
            unique case (r_state)
                gve_pkg::S_IDLE: begin
                    if (w_accept) begin
                        r_pos[0] <= i_pos_x;
                        r_pos[1] <= i_pos_y;
                        r_pos[2] <= i_pos_z;
                        r_stamp  <= i_stamp_us;
                        if (!r_started) begin
                            r_started   <= 1'b1;
                            r_last[0]   <= i_pos_x;
                            r_last[1]   <= i_pos_y;
                            r_last[2]   <= i_pos_z;
                            r_last_time <= i_stamp_us;
                        end
                    end
                end
                gve_pkg::S_CHECK: begin
                    r_status <= gve_pkg::ST_SHORT;
                    r_dt     <= w_dt;
                    for (int k = 0; k < 3; k++) begin
                        logic signed [32:0] dp;
                        dp = 33'(r_pos[k]) - 33'(r_last[k]);
                        r_neg[k] <= dp[32];
                        r_mag[k] <= dp[32] ? 33'(-dp) : 33'(dp);
                    end
                end
                gve_pkg::S_MUL: begin
                    for (int k = 0; k < 3; k++) r_num[k] <= NW'(r_mag[k] * gve_pkg::SCALE_US);
                    r_t <= 42'(r_lim * r_dt);
                end
                gve_pkg::S_SAT: begin
                    for (int k = 0; k < 3; k++) begin
                        if (r_neg[k]) begin
                            r_vel[k] <= (w_quo[k] > NW'(33'h080000000)) ? 32'sh80000000
                                                                       : 32'(-w_quo[k]);
                        end else begin
                            r_vel[k] <= (w_quo[k] > NW'(32'h7fffffff)) ? 32'sh7fffffff
                                                                      : 32'(w_quo[k]);
                        end
                    end
                end
                gve_pkg::S_DIFF: begin
                    for (int k = 0; k < 3; k++) begin
                        logic signed [32:0] df;
                        df = 33'(r_vel[k]) - 33'(r_hist[k][0]);
                        r_d[k] <= df[32] ? 32'(-df) : 32'(df);
                    end
                    r_sum <= '0;
                    r_thr <= '0;
                    r_cnt <= '0;
                end
                gve_pkg::S_SQ: begin
                    r_prod <= w_ma * w_mb;
                    r_cnt  <= r_cnt + 1'b1;
                    unique case (r_cnt)
                        gve_pkg::CNT_W'(1), gve_pkg::CNT_W'(2), gve_pkg::CNT_W'(3):
                            r_sum <= r_sum + 66'(r_prod);
                        gve_pkg::CNT_W'(4): r_thr <= r_thr + (84'(r_prod) << 42);
                        gve_pkg::CNT_W'(5): r_thr <= r_thr + (84'(r_prod) << 22);
                        gve_pkg::CNT_W'(6): r_thr <= r_thr + 84'(r_prod);
                        default: ;
                    endcase
                end
                gve_pkg::S_CMP: begin
                    r_status <= gve_pkg::ST_OUTLIER;
                    r_cnt    <= '0;
                    for (int k = 0; k < 3; k++) r_acc[k] <= SW'(r_vel[k]);
                end
                gve_pkg::S_SUM: begin
                    r_cnt <= r_cnt + 1'b1;
                    for (int k = 0; k < 3; k++) begin
                        r_acc[k]     <= r_acc[k] + SW'(r_hist[k][HL-1]);
                        r_hist[k][0] <= r_hist[k][HL-1];
                        for (int j = 1; j < HL; j++) r_hist[k][j] <= r_hist[k][j-1];
                    end
                end
                gve_pkg::S_PUSH: begin
                    r_status    <= gve_pkg::ST_OK;
                    r_last_time <= r_stamp;
                    for (int k = 0; k < 3; k++) begin
                        r_fv[k]      <= r_acc[k][SW-1] ? 32'(-w_quo[k]) : 32'(w_quo[k]);
                        r_last[k]    <= r_pos[k];
                        r_hist[k][0] <= r_vel[k];
                        for (int j = 1; j < HL; j++) r_hist[k][j] <= r_hist[k][j-1];
                    end
                end
                gve_pkg::S_DONE: begin
                    if (w_load) begin
                        r_ostat  <= r_status;
                        for (int k = 0; k < 3; k++) begin
                            r_opos[k] <= r_pos[k];
                            r_ovel[k] <= r_fv[k];
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_valid         = r_ovalid;
    assign o_out_pos_x     = r_opos[0];
    assign o_out_pos_y     = r_opos[1];
    assign o_out_pos_z     = r_opos[2];
    assign o_vel_x         = r_ovel[0];
    assign o_vel_y         = r_ovel[1];
    assign o_vel_z         = r_ovel[2];
    assign o_sample_status = r_ostat;

endmodule

[rtl/gve_div.sv]
// Bit-serial restoring unsigned divider, one quotient bit per cycle.
module gve_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [gve_pkg::DIV_NW-1:0]     i_dvd,
    input  logic [gve_pkg::DIV_DW-1:0]     i_dvs,
    output logic [gve_pkg::DIV_NW-1:0]     o_quo,
    output logic                           o_busy
);

    logic [gve_pkg::DIV_CW-1:0] r_cnt;
    logic [gve_pkg::DIV_DW:0]   r_rem;
    logic [gve_pkg::DIV_NW-1:0] r_quo;
    logic [gve_pkg::DIV_DW-1:0] r_dvs;
    logic [gve_pkg::DIV_DW:0]   w_trial;
    logic [gve_pkg::DIV_DW:0]   w_next;
    logic                       w_ge;

    always_comb begin
        w_trial = {r_rem[gve_pkg::DIV_DW-1:0], r_quo[gve_pkg::DIV_NW-1]};
        w_ge    = w_trial >= {1'b0, r_dvs};
        w_next  = w_ge ? (w_trial - {1'b0, r_dvs}) : w_trial;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= gve_pkg::DIV_CW'(gve_pkg::DIV_NW);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dvd;
            r_dvs <= i_dvs;
        end else if (r_cnt != '0) begin
            r_rem <= w_next;
            r_quo <= {r_quo[gve_pkg::DIV_NW-2:0], w_ge};
        end
    end

    assign o_quo  = r_quo;
    assign o_busy = r_cnt != '0;

endmodule
